>>> rtl/hsv_pkg.sv
// shared constants and types for the hsv to rgb converter
package hsv_pkg;

    // default component width
    localparam int COMPONENT_BITS = 16;

    // hue sector codes, one per sixth of a turn
    localparam logic [2:0] SEC_RED     = 3'd0;
    localparam logic [2:0] SEC_YELLOW  = 3'd1;
    localparam logic [2:0] SEC_GREEN   = 3'd2;
    localparam logic [2:0] SEC_CYAN    = 3'd3;
    localparam logic [2:0] SEC_BLUE    = 3'd4;
    localparam logic [2:0] SEC_MAGENTA = 3'd5;

    // control that travels with each request down the pipeline
    typedef struct packed {
        logic       valid;
        logic       grey;
        logic [2:0] sector;
    } t_ctrl;

endpackage

>>> rtl/hsv_div_max.sv
// rounded division of a double-width product by the full-scale value 2^B-1
module hsv_div_max #(
    parameter int B = hsv_pkg::COMPONENT_BITS
) (
    input  logic [2*B-1:0] i_prod,
    output logic [B-1:0]   o_quot
);
    localparam logic [2*B-1:0] HALF_MAX = {{(B+1){1'b0}}, {(B-1){1'b1}}};

    logic [2*B-1:0] n_sum;
    logic [B:0]     n_rem;

    // x / (2^B-1) = hi + carry of (lo + hi + 1); sum stays below 2^(2B)
    always_comb begin
        n_sum  = i_prod + HALF_MAX;
        n_rem  = {1'b0, n_sum[B-1:0]} + {1'b0, n_sum[2*B-1:B]} + {{B{1'b0}}, 1'b1};
        o_quot = n_sum[2*B-1:B] + {{(B-1){1'b0}}, n_rem[B]};
    end

endmodule

>>> rtl/hsv_hue_stage.sv
// first stage: hue sector and fraction, grey test, product for p
module hsv_hue_stage #(
    parameter int B = hsv_pkg::COMPONENT_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [B-1:0]     i_hue,
    input  logic [B-1:0]     i_sat,
    input  logic [B-1:0]     i_val,
    output hsv_pkg::t_ctrl   o_ctrl,
    output logic [B-1:0]     o_frac,
    output logic [B-1:0]     o_sat,
    output logic [B-1:0]     o_val,
    output logic [2*B-1:0]   o_pprod
);
    localparam logic [B-1:0] GREY_LIMIT = B'(((1 << B) - 1) / 10000 + 1);

    logic [B+2:0]   n_h6;
    hsv_pkg::t_ctrl n_ctrl;
    logic [2*B-1:0] n_pprod;
    hsv_pkg::t_ctrl r_ctrl;
    logic [B-1:0]   r_frac;
    logic [B-1:0]   r_sat;
    logic [B-1:0]   r_val;
    logic [2*B-1:0] r_pprod;

    // hue times six as 4h + 2h, split into sector and fraction
    always_comb begin
        n_h6          = ({3'b000, i_hue} << 2) + ({3'b000, i_hue} << 1);
        n_ctrl.valid  = i_valid;
        n_ctrl.grey   = (i_sat < GREY_LIMIT);
        n_ctrl.sector = n_h6[B+2:B];
        n_pprod       = {{B{1'b0}}, i_val} * {{B{1'b0}}, ~i_sat};
    end

    // valid bit under reset, payload free-running
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl.valid <= 1'b0;
        end else begin
            r_ctrl.valid <= n_ctrl.valid;
        end
        r_ctrl.grey   <= n_ctrl.grey;
        r_ctrl.sector <= n_ctrl.sector;
        r_frac        <= n_h6[B-1:0];
        r_sat         <= i_sat;
        r_val         <= i_val;
        r_pprod       <= n_pprod;
    end

    assign o_ctrl  = r_ctrl;
    assign o_frac  = r_frac;
    assign o_sat   = r_sat;
    assign o_val   = r_val;
    assign o_pprod = r_pprod;

endmodule

>>> rtl/hsv_frac_stage.sv
// second and third stages: s*f and s*(1-f) products, rounding, p
module hsv_frac_stage #(
    parameter int B = hsv_pkg::COMPONENT_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  hsv_pkg::t_ctrl   i_ctrl,
    input  logic [B-1:0]     i_frac,
    input  logic [B-1:0]     i_sat,
    input  logic [B-1:0]     i_val,
    input  logic [2*B-1:0]   i_pprod,
    output hsv_pkg::t_ctrl   o_ctrl,
    output logic [B-1:0]     o_val,
    output logic [B-1:0]     o_p,
    output logic [B-1:0]     o_inv_sf,
    output logic [B-1:0]     o_inv_sft
);
    localparam logic [B:0]     FULL_TURN = {1'b1, {B{1'b0}}};
    localparam logic [2*B:0]   HALF_TURN = {{(B+1){1'b0}}, 1'b1, {(B-1){1'b0}}};

    logic [B:0]     n_comp;
    logic [2*B-1:0] n_sf_prod;
    logic [2*B:0]   n_sft_prod;
    logic [B-1:0]   n_p;
    logic [2*B:0]   n_sf_sum;
    logic [2*B:0]   n_sft_sum;

    hsv_pkg::t_ctrl r_ctrl2;
    logic [B-1:0]   r_val2;
    logic [B-1:0]   r_p2;
    logic [2*B-1:0] r_sf_prod;
    logic [2*B:0]   r_sft_prod;
    hsv_pkg::t_ctrl r_ctrl3;
    logic [B-1:0]   r_val3;
    logic [B-1:0]   r_p3;
    logic [B-1:0]   r_inv_sf;
    logic [B-1:0]   r_inv_sft;

    // p = v(1-s) rounded over full scale
    hsv_div_max #(.B(B)) u_div_p (
        .i_prod (i_pprod),
        .o_quot (n_p)
    );

    // saturation times fraction and times its complement
    always_comb begin
        n_comp     = FULL_TURN - {1'b0, i_frac};
        n_sf_prod  = {{B{1'b0}}, i_sat} * {{B{1'b0}}, i_frac};
        n_sft_prod = {{(B+1){1'b0}}, i_sat} * {{B{1'b0}}, n_comp};
    end

    // round half up, both products stay at or below full scale
    always_comb begin
        n_sf_sum  = {1'b0, r_sf_prod} + HALF_TURN;
        n_sft_sum = r_sft_prod + HALF_TURN;
    end

    // valid bits under reset; payload, complements taken as inversion
    // since full scale is all ones
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl2.valid <= 1'b0;
            r_ctrl3.valid <= 1'b0;
        end else begin
            r_ctrl2.valid <= i_ctrl.valid;
            r_ctrl3.valid <= r_ctrl2.valid;
        end
        r_ctrl2.grey   <= i_ctrl.grey;
        r_ctrl2.sector <= i_ctrl.sector;
        r_val2         <= i_val;
        r_p2           <= n_p;
        r_sf_prod      <= n_sf_prod;
        r_sft_prod     <= n_sft_prod;
        r_ctrl3.grey   <= r_ctrl2.grey;
        r_ctrl3.sector <= r_ctrl2.sector;
        r_val3         <= r_val2;
        r_p3           <= r_p2;
        r_inv_sf       <= ~n_sf_sum[2*B-1:B];
        r_inv_sft      <= ~n_sft_sum[2*B-1:B];
    end

    assign o_ctrl    = r_ctrl3;
    assign o_val     = r_val3;
    assign o_p       = r_p3;
    assign o_inv_sf  = r_inv_sf;
    assign o_inv_sft = r_inv_sft;

endmodule

>>> rtl/hsv_mix_stage.sv
// fourth and fifth stages: q and t, sector routing, output registers
module hsv_mix_stage #(
    parameter int B = hsv_pkg::COMPONENT_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  hsv_pkg::t_ctrl   i_ctrl,
    input  logic [B-1:0]     i_val,
    input  logic [B-1:0]     i_p,
    input  logic [B-1:0]     i_inv_sf,
    input  logic [B-1:0]     i_inv_sft,
    output logic             o_valid,
    output logic [B-1:0]     o_red,
    output logic [B-1:0]     o_green,
    output logic [B-1:0]     o_blue
);
    hsv_pkg::t_ctrl r_ctrl4;
    logic [B-1:0]   r_val4;
    logic [B-1:0]   r_p4;
    logic [2*B-1:0] r_qprod;
    logic [2*B-1:0] r_tprod;
    logic [B-1:0]   n_q;
    logic [B-1:0]   n_t;
    logic [B-1:0]   n_red;
    logic [B-1:0]   n_green;
    logic [B-1:0]   n_blue;
    logic           r_valid;
    logic           r_grey;
    logic [B-1:0]   r_red;
    logic [B-1:0]   r_green;
    logic [B-1:0]   r_blue;

    // q and t rounded over full scale
    hsv_div_max #(.B(B)) u_div_q (
        .i_prod (r_qprod),
        .o_quot (n_q)
    );

    hsv_div_max #(.B(B)) u_div_t (
        .i_prod (r_tprod),
        .o_quot (n_t)
    );

    // route v, p, q, t to the channels by sector; grey pixels get v on all three
    always_comb begin
        case (r_ctrl4.sector)
            hsv_pkg::SEC_RED: begin
                n_red = r_val4; n_green = n_t;    n_blue = r_p4;
            end
            hsv_pkg::SEC_YELLOW: begin
                n_red = n_q;    n_green = r_val4; n_blue = r_p4;
            end
            hsv_pkg::SEC_GREEN: begin
                n_red = r_p4;   n_green = r_val4; n_blue = n_t;
            end
            hsv_pkg::SEC_CYAN: begin
                n_red = r_p4;   n_green = n_q;    n_blue = r_val4;
            end
            hsv_pkg::SEC_BLUE: begin
                n_red = n_t;    n_green = r_p4;   n_blue = r_val4;
            end
            hsv_pkg::SEC_MAGENTA: begin
                n_red = r_val4; n_green = r_p4;   n_blue = n_q;
            end
            default: begin
                n_red = r_val4; n_green = r_p4;   n_blue = n_q;
            end
        endcase
        if (r_ctrl4.grey) begin
            n_red   = r_val4;
            n_green = r_val4;
            n_blue  = r_val4;
        end
    end

    // valid bits under reset, payload free-running
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl4.valid <= 1'b0;
            r_valid       <= 1'b0;
        end else begin
            r_ctrl4.valid <= i_ctrl.valid;
            r_valid       <= r_ctrl4.valid;
        end
        r_ctrl4.grey   <= i_ctrl.grey;
        r_ctrl4.sector <= i_ctrl.sector;
        r_val4         <= i_val;
        r_p4           <= i_p;
        r_qprod        <= {{B{1'b0}}, i_val} * {{B{1'b0}}, i_inv_sf};
        r_tprod        <= {{B{1'b0}}, i_val} * {{B{1'b0}}, i_inv_sft};
        r_grey         <= r_ctrl4.grey;
        r_red          <= n_red;
        r_green        <= n_green;
        r_blue         <= n_blue;
    end

    assign o_valid = r_valid;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

    // grey pixels leave with equal channels
    a_grey_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_grey) |-> (r_red == r_green && r_green == r_blue))
        else $error("grey pixel with unequal channels");

    // a result strobe follows a valid request in the stage before
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $past(r_ctrl4.valid))
        else $error("result strobe without request in last stage");

endmodule

>>> rtl/hsv_to_rgb_converter.sv
// top level of the hsv to rgb pixel converter
//
//  channel   direction  handshake           payload
//  request   in         i_start / o_busy    i_hue, i_sat, i_val
//  result    out        o_valid (strobe)    o_red, o_green, o_blue
//
// one request per clock; o_busy is always low
// the result strobe follows the request through the hue, fraction
// and mix stages, set by the two multiply-and-divide chains (s*f then v*q)
// synchronous active-low reset clears the valid bits of all stages
// the receiver cannot stall, so the pipeline never holds
module hsv_to_rgb_converter #(
    parameter int COMPONENT_BITS = hsv_pkg::COMPONENT_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    output logic                      o_busy,
    input  logic [COMPONENT_BITS-1:0] i_hue,
    input  logic [COMPONENT_BITS-1:0] i_sat,
    input  logic [COMPONENT_BITS-1:0] i_val,
    output logic                      o_valid,
    output logic [COMPONENT_BITS-1:0] o_red,
    output logic [COMPONENT_BITS-1:0] o_green,
    output logic [COMPONENT_BITS-1:0] o_blue
);
    localparam int B = COMPONENT_BITS;

    hsv_pkg::t_ctrl s1_ctrl;
    logic [B-1:0]   s1_frac;
    logic [B-1:0]   s1_sat;
    logic [B-1:0]   s1_val;
    logic [2*B-1:0] s1_pprod;
    hsv_pkg::t_ctrl s3_ctrl;
    logic [B-1:0]   s3_val;
    logic [B-1:0]   s3_p;
    logic [B-1:0]   s3_inv_sf;
    logic [B-1:0]   s3_inv_sft;

    // pipeline always takes a request
    assign o_busy = 1'b0;

    // sector, fraction and p product
    hsv_hue_stage #(.B(B)) u_hue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_start && !o_busy),
        .i_hue   (i_hue),
        .i_sat   (i_sat),
        .i_val   (i_val),
        .o_ctrl  (s1_ctrl),
        .o_frac  (s1_frac),
        .o_sat   (s1_sat),
        .o_val   (s1_val),
        .o_pprod (s1_pprod)
    );

    // saturation scaled by fraction and its complement, and p rounded
    hsv_frac_stage #(.B(B)) u_frac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (s1_ctrl),
        .i_frac    (s1_frac),
        .i_sat     (s1_sat),
        .i_val     (s1_val),
        .i_pprod   (s1_pprod),
        .o_ctrl    (s3_ctrl),
        .o_val     (s3_val),
        .o_p       (s3_p),
        .o_inv_sf  (s3_inv_sf),
        .o_inv_sft (s3_inv_sft)
    );

    // q, t and channel routing
    hsv_mix_stage #(.B(B)) u_mix (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (s3_ctrl),
        .i_val     (s3_val),
        .i_p       (s3_p),
        .i_inv_sf  (s3_inv_sf),
        .i_inv_sft (s3_inv_sft),
        .o_valid   (o_valid),
        .o_red     (o_red),
        .o_green   (o_green),
        .o_blue    (o_blue)
    );

    // never busy
    a_never_busy: assert property (@(posedge i_clk) o_busy == 1'b0)
        else $error("busy raised");

    // every strobe traces back to an earlier request on i_start
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, 5))
        else $error("result strobe without matching request");

endmodule

>>> test/tb.sv
// testbench for the hsv to rgb converter: directed and randomized pixels checked against a bit-exact predictor
`timescale 1ns / 100ps

module tb;

    localparam int CB = hsv_pkg::COMPONENT_BITS;
    localparam bit [63:0] C_MAX = (64'd1 << CB) - 64'd1;
    localparam bit [63:0] C_TURN = 64'd1 << CB;
    localparam bit [63:0] C_HALF = 64'd1 << (CB - 1);
    localparam bit [63:0] GREY_FLOOR = C_MAX / 64'd10000 + 64'd1;
    localparam int RANDOM_PIXELS = 400;
    localparam int SETTLE_CYCLES = 12;
    localparam int STALL_LIMIT = 2000;
    localparam int SHOW_LIMIT = 10;

    typedef struct packed {
        logic [CB-1:0] hue;
        logic [CB-1:0] sat;
        logic [CB-1:0] val;
    } t_hsv;

    typedef struct packed {
        logic [CB-1:0] red;
        logic [CB-1:0] green;
        logic [CB-1:0] blue;
    } t_rgb;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_start = 1'b0;
    logic [CB-1:0] i_hue = '0;
    logic [CB-1:0] i_sat = '0;
    logic [CB-1:0] i_val = '0;
    logic          o_busy;
    logic          o_valid;
    logic [CB-1:0] o_red;
    logic [CB-1:0] o_green;
    logic [CB-1:0] o_blue;

    t_hsv pixel_q[$];
    t_rgb rgb_expected[$];
    int   pixel_total = 0;
    int   pixels_sent = 0;
    int   error_count = 0;
    int   stall_cycles = 0;
    logic req_taken = 1'b0;

    hsv_to_rgb_converter #(
        .COMPONENT_BITS(CB)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_start),
        .o_busy (o_busy),
        .i_hue  (i_hue),
        .i_sat  (i_sat),
        .i_val  (i_val),
        .o_valid(o_valid),
        .o_red  (o_red),
        .o_green(o_green),
        .o_blue (o_blue)
    );

    // clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // bit-exact color conversion in wide unsigned arithmetic
    function automatic t_rgb predict_rgb(input t_hsv px);
        bit [63:0] h;
        bit [63:0] s;
        bit [63:0] v;
        bit [63:0] h6;
        bit [63:0] f;
        bit [63:0] sf;
        bit [63:0] sft;
        bit [63:0] pv;
        bit [63:0] qv;
        bit [63:0] tv;
        bit [63:0] r;
        bit [63:0] g;
        bit [63:0] b;
        bit [2:0]  sector;
        t_rgb      c;
        h = 64'(px.hue);
        s = 64'(px.sat);
        v = 64'(px.val);
        if (s < GREY_FLOOR) begin
            r = v;
            g = v;
            b = v;
        end else begin
            h6 = h * 64'd6;
            sector = 3'(h6 >> CB);
            f = h6 & C_MAX;
            // fractions of a turn round half up, fractions of full scale round to nearest
            sf = (s * f + C_HALF) >> CB;
            sft = (s * (C_TURN - f) + C_HALF) >> CB;
            pv = (v * (C_MAX - s) + (C_MAX >> 1)) / C_MAX;
            qv = (v * (C_MAX - sf) + (C_MAX >> 1)) / C_MAX;
            tv = (v * (C_MAX - sft) + (C_MAX >> 1)) / C_MAX;
            case (sector)
                hsv_pkg::SEC_RED: begin
                    r = v;  g = tv; b = pv;
                end
                hsv_pkg::SEC_YELLOW: begin
                    r = qv; g = v;  b = pv;
                end
                hsv_pkg::SEC_GREEN: begin
                    r = pv; g = v;  b = tv;
                end
                hsv_pkg::SEC_CYAN: begin
                    r = pv; g = qv; b = v;
                end
                hsv_pkg::SEC_BLUE: begin
                    r = tv; g = pv; b = v;
                end
                default: begin
                    r = v;  g = pv; b = qv;
                end
            endcase
        end
        c.red = r[CB-1:0];
        c.green = g[CB-1:0];
        c.blue = b[CB-1:0];
        return c;
    endfunction

    // one field compare, first few mismatches shown
    task automatic check_field(input string field, input logic [CB-1:0] want,
                               input logic [CB-1:0] got);
        if (got !== want) begin
            error_count++;
            if (error_count <= SHOW_LIMIT)
                $display("tb: %s mismatch at %0t: expected %0d, got %0d", field, $realtime,
                         want, got);
        end
    endtask

    // driver: presents the next pixel once the previous request is taken
    always @(negedge i_clk) begin : drive
        t_hsv next_px;
        int   idle_pct;
        if (i_rst_n && (!i_start || req_taken)) begin
            if (pixels_sent < pixel_total / 3)
                idle_pct = 7;
            else if (pixels_sent < 2 * pixel_total / 3)
                idle_pct = 60;
            else
                idle_pct = 0;
            if (pixel_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                next_px = pixel_q.pop_front();
                pixels_sent++;
                i_start <= 1'b1;
                i_hue <= next_px.hue;
                i_sat <= next_px.sat;
                i_val <= next_px.val;
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // monitor: predicts on each accepted request and checks each result strobe
    always @(posedge i_clk) begin : monitor
        t_rgb want;
        req_taken <= i_rst_n && i_start && (o_busy === 1'b0);
        if (i_rst_n && i_start && o_busy === 1'b0)
            rgb_expected.push_back(predict_rgb('{hue: i_hue, sat: i_sat, val: i_val}));
        if (i_rst_n && o_valid === 1'b1) begin
            if (rgb_expected.size() == 0) begin
                error_count++;
                if (error_count <= SHOW_LIMIT)
                    $display("tb: unexpected result at %0t: %0d %0d %0d", $realtime,
                             o_red, o_green, o_blue);
            end else begin
                want = rgb_expected.pop_front();
                check_field("red", want.red, o_red);
                check_field("green", want.green, o_green);
                check_field("blue", want.blue, o_blue);
            end
        end
    end

    // watchdog on cycles with no request and no result
    always @(posedge i_clk) begin : watchdog
        if (i_rst_n && !(i_start && o_busy === 1'b0) && o_valid !== 1'b1)
            stall_cycles <= stall_cycles + 1;
        else
            stall_cycles <= 0;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // stimulus, reset and end of run
    initial begin : stimulus
        t_hsv px;
        int   mode;
        int   k;
        // sector edges, both scale ends, grey threshold, zero value
        pixel_q.push_back('{hue: 16'd0,     sat: 16'hFFFF, val: 16'hFFFF});
        pixel_q.push_back('{hue: 16'hFFFF,  sat: 16'hFFFF, val: 16'hFFFF});
        pixel_q.push_back('{hue: 16'd10922, sat: 16'hFFFF, val: 16'hFFFF});
        pixel_q.push_back('{hue: 16'd10923, sat: 16'hFFFF, val: 16'hFFFF});
        pixel_q.push_back('{hue: 16'd21845, sat: 16'hFFFF, val: 16'd50000});
        pixel_q.push_back('{hue: 16'd21846, sat: 16'hFFFF, val: 16'd50000});
        pixel_q.push_back('{hue: 16'd32768, sat: 16'd40000, val: 16'hFFFF});
        pixel_q.push_back('{hue: 16'd43690, sat: 16'd40000, val: 16'd30000});
        pixel_q.push_back('{hue: 16'd43691, sat: 16'd40000, val: 16'd30000});
        pixel_q.push_back('{hue: 16'd54613, sat: 16'd20000, val: 16'hFFFF});
        pixel_q.push_back('{hue: 16'd54614, sat: 16'd20000, val: 16'hFFFF});
        pixel_q.push_back('{hue: 16'd5000,  sat: 16'd0,     val: 16'd40000});
        pixel_q.push_back('{hue: 16'd20000, sat: 16'd6,     val: 16'd12345});
        pixel_q.push_back('{hue: 16'd20000, sat: 16'd7,     val: 16'd12345});
        pixel_q.push_back('{hue: 16'd30000, sat: 16'hFFFF, val: 16'd0});
        pixel_q.push_back('{hue: 16'd40000, sat: 16'hFFFF, val: 16'd1});
        pixel_q.push_back('{hue: 16'd50000, sat: 16'd32768, val: 16'hFFFF});
        pixel_q.push_back('{hue: 16'd60000, sat: 16'd1,     val: 16'hFFFF});
        pixel_q.push_back('{hue: 16'h5555,  sat: 16'hAAAA,  val: 16'h5555});
        pixel_q.push_back('{hue: 16'hAAAA,  sat: 16'h5555,  val: 16'hAAAA});
        // random pixels, biased toward grey, sector edges and scale ends
        repeat (RANDOM_PIXELS) begin
            mode = $urandom_range(0, 9);
            px.hue = CB'($urandom);
            px.sat = CB'($urandom);
            px.val = CB'($urandom);
            case (mode)
                0: px.sat = CB'($urandom_range(0, 10));
                1: begin
                    k = $urandom_range(1, 5);
                    px.hue = CB'((k * (1 << CB)) / 6 + $urandom_range(0, 4) - 2);
                end
                2: px.val = $urandom_range(0, 1) ? CB'($urandom_range(0, 1))
                                                 : CB'(C_MAX - $urandom_range(0, 1));
                3: px.sat = CB'(C_MAX);
                default: ;
            endcase
            pixel_q.push_back(px);
        end
        pixel_total = pixel_q.size();
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        // drain
        while (pixel_q.size() > 0 || i_start || rgb_expected.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0 && rgb_expected.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
